// ===== design/jsv_pkg.sv =====
// shared types, codes and helper functions for the json syntax validator
package jsv_pkg;

  localparam int STACK_DEPTH = 13;
  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int CFG_W = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_KEY = 1'd1;

  // error codes
  localparam logic [3:0] ERR_NONE     = 4'd0;
  localparam logic [3:0] ERR_UNEXP    = 4'd1;
  localparam logic [3:0] ERR_ESCAPE   = 4'd2;
  localparam logic [3:0] ERR_CTRL     = 4'd3;
  localparam logic [3:0] ERR_NUMBER   = 4'd4;
  localparam logic [3:0] ERR_DEEP     = 4'd5;
  localparam logic [3:0] ERR_KEY_LONG = 4'd6;
  localparam logic [3:0] ERR_EARLY    = 4'd7;
  localparam logic [3:0] ERR_TRAILING = 4'd8;

  // parser modes
  typedef enum logic [4:0] {
    M_VALUE     = 5'd0,
    M_ARR_FIRST = 5'd1,
    M_OBJ_FIRST = 5'd2,
    M_KEY       = 5'd3,
    M_COLON     = 5'd4,
    M_AFTER     = 5'd5,
    M_DONE      = 5'd6,
    M_STR       = 5'd7,
    M_KEYSTR    = 5'd8,
    M_LIT       = 5'd9,
    N_SIGN      = 5'd10,
    N_ZERO      = 5'd11,
    N_INT       = 5'd12,
    N_DOT       = 5'd13,
    N_FRAC      = 5'd14,
    N_EXP       = 5'd15,
    N_ESIGN     = 5'd16,
    N_EXPD      = 5'd17
  } mode_t;

  // literal kinds
  localparam logic [1:0] LIT_TRUE  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;

  // parser state between bytes
  typedef struct packed {
    mode_t                  mode;
    logic [STACK_DEPTH-1:0] stack;
    logic [DEPTH_W-1:0]     depth;
    logic                   in_escape;
    logic [2:0]             hex_left;
    logic [1:0]             lit_kind;
    logic [2:0]             lit_index;
    logic [7:0]             key_len;
    logic [3:0]             err;
  } pstate_t;

  typedef struct packed {
    logic       is_valid;
    logic [3:0] error_code;
  } result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  // expected character of a literal at a position, zero past its end
  function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] i);
    logic [7:0] r;
    r = 8'h00;
    unique case (k)
      LIT_TRUE: begin
        unique case (i)
          3'd0: r = "t";
          3'd1: r = "r";
          3'd2: r = "u";
          3'd3: r = "e";
          default: r = 8'h00;
        endcase
      end
      LIT_FALSE: begin
        unique case (i)
          3'd0: r = "f";
          3'd1: r = "a";
          3'd2: r = "l";
          3'd3: r = "s";
          3'd4: r = "e";
          default: r = 8'h00;
        endcase
      end
      LIT_NULL: begin
        unique case (i)
          3'd0: r = "n";
          3'd1: r = "u";
          3'd2: r = "l";
          3'd3: r = "l";
          default: r = 8'h00;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] k);
    return (k == LIT_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic pstate_t reset_state();
    pstate_t s;
    s = '0;
    s.mode = M_VALUE;
    return s;
  endfunction

endpackage

// ===== design/jsv_stream_if.sv =====
// valid/ready channel interface carrying a generic payload
interface jsv_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/jsv_step.sv =====
// next-state logic of the parser for one text byte
module jsv_step import jsv_pkg::*; (
  input  pstate_t    cur,
  input  logic [7:0] c,
  input  logic       last,
  input  logic [3:0] depth_limit,
  input  logic [7:0] max_key_bytes,
  output pstate_t    nxt,
  output result_t    res
);

  logic [DEPTH_W-1:0] lim;
  pstate_t s;
  pstate_t f;
  logic used;
  logic top_obj;
  logic is_e;
  logic key;
  logic esc_ok;
  logic count_key;

  // effective depth limit
  always_comb begin
    if ({{(DEPTH_W > 4 ? DEPTH_W - 4 : 0){1'b0}}, depth_limit} > (DEPTH_W)'(STACK_DEPTH - 1))
      lim = (DEPTH_W)'(STACK_DEPTH - 1);
    else
      lim = (DEPTH_W)'(depth_limit);
  end

  // feed one byte
  always_comb begin
    s = cur;
    used = 1'b0;
    is_e = c == "e" || c == "E";
    key = cur.mode == M_KEYSTR;
    esc_ok = c == 8'h22 || c == 8'h5C || c == "/" || c == "b" || c == "f" ||
             c == "n" || c == "r" || c == "t";
    count_key = 1'b0;
    top_obj = 1'b0;
    if (cur.err == ERR_NONE) begin
      // number modes first; a byte that ends a number falls through
      if (cur.mode >= N_SIGN) begin
        used = 1'b1;
        unique case (cur.mode)
          N_SIGN: begin
            if (c == "0") s.mode = N_ZERO;
            else if (is_digit(c)) s.mode = N_INT;
            else s.err = ERR_NUMBER;
          end
          N_ZERO, N_INT: begin
            if (cur.mode == N_INT && is_digit(c)) used = 1'b1;
            else if (c == ".") s.mode = N_DOT;
            else if (is_e) s.mode = N_EXP;
            else used = 1'b0;
          end
          N_DOT: begin
            if (is_digit(c)) s.mode = N_FRAC;
            else s.err = ERR_NUMBER;
          end
          N_FRAC: begin
            if (is_digit(c)) used = 1'b1;
            else if (is_e) s.mode = N_EXP;
            else used = 1'b0;
          end
          N_EXP: begin
            if (c == "+" || c == "-") s.mode = N_ESIGN;
            else if (is_digit(c)) s.mode = N_EXPD;
            else s.err = ERR_NUMBER;
          end
          N_ESIGN: begin
            if (is_digit(c)) s.mode = N_EXPD;
            else s.err = ERR_NUMBER;
          end
          default: used = is_digit(c);
        endcase
        if (!used) s.mode = (cur.depth == '0) ? M_DONE : M_AFTER;
      end
      top_obj = (s.depth == '0) ? 1'b0 : s.stack[s.depth - 1'b1];
      if (!used) begin
        unique case (s.mode)
          M_VALUE, M_ARR_FIRST: begin
            if (is_ws(c)) begin
            end else if (s.mode == M_ARR_FIRST && c == "]") begin
              s.depth = s.depth - 1'b1;
              s.mode = (s.depth == '0) ? M_DONE : M_AFTER;
            end else if (s.depth > lim) begin
              s.err = ERR_DEEP;
            end else if (c == 8'h22) begin
              s.mode = M_STR;
              s.in_escape = 1'b0;
              s.hex_left = '0;
              s.key_len = '0;
            end else if (c == "{" || c == "[") begin
              s.stack[s.depth] = c == "{";
              s.depth = s.depth + 1'b1;
              s.mode = (c == "{") ? M_OBJ_FIRST : M_ARR_FIRST;
            end else if (c == "t" || c == "f" || c == "n") begin
              s.lit_kind = (c == "t") ? LIT_TRUE : ((c == "f") ? LIT_FALSE : LIT_NULL);
              s.lit_index = 3'd1;
              s.mode = M_LIT;
            end else if (c == "-") s.mode = N_SIGN;
            else if (c == "0") s.mode = N_ZERO;
            else if (is_digit(c)) s.mode = N_INT;
            else s.err = ERR_UNEXP;
          end
          M_OBJ_FIRST, M_KEY: begin
            if (is_ws(c)) begin
            end else if (s.mode == M_OBJ_FIRST && c == "}") begin
              s.depth = s.depth - 1'b1;
              s.mode = (s.depth == '0) ? M_DONE : M_AFTER;
            end else if (c == 8'h22) begin
              s.mode = M_KEYSTR;
              s.in_escape = 1'b0;
              s.hex_left = '0;
              s.key_len = '0;
            end else s.err = ERR_UNEXP;
          end
          M_COLON: begin
            if (is_ws(c)) begin
            end else if (c == ":") s.mode = M_VALUE;
            else s.err = ERR_UNEXP;
          end
          M_AFTER: begin
            if (is_ws(c)) begin
            end else if (c == ",") s.mode = top_obj ? M_KEY : M_VALUE;
            else if ((c == "]" && !top_obj) || (c == "}" && top_obj)) begin
              s.depth = s.depth - 1'b1;
              s.mode = (s.depth == '0) ? M_DONE : M_AFTER;
            end else s.err = ERR_UNEXP;
          end
          M_DONE: begin
            if (!is_ws(c)) s.err = ERR_TRAILING;
          end
          M_STR, M_KEYSTR: begin
            if (s.hex_left != '0) begin
              if (!is_hex(c)) s.err = ERR_ESCAPE;
              else begin
                s.hex_left = s.hex_left - 1'b1;
                count_key = 1'b1;
              end
            end else if (s.in_escape) begin
              s.in_escape = 1'b0;
              if (c == "u") begin
                s.hex_left = 3'd4;
                count_key = 1'b1;
              end else if (esc_ok) count_key = 1'b1;
              else s.err = ERR_ESCAPE;
            end else if (c == 8'h22) begin
              if (key) s.mode = M_COLON;
              else s.mode = (s.depth == '0) ? M_DONE : M_AFTER;
            end else if (c < 8'h20) begin
              s.err = ERR_CTRL;
            end else begin
              if (c == 8'h5C) s.in_escape = 1'b1;
              count_key = 1'b1;
            end
            if (count_key && key) begin
              if (s.key_len >= max_key_bytes) s.err = ERR_KEY_LONG;
              else s.key_len = s.key_len + 1'b1;
            end
          end
          M_LIT: begin
            if (s.lit_kind > LIT_NULL || s.lit_index >= lit_len(s.lit_kind) ||
                lit_char(s.lit_kind, s.lit_index) != c) begin
              s.err = ERR_UNEXP;
            end else begin
              s.lit_index = s.lit_index + 1'b1;
              if (s.lit_index == lit_len(s.lit_kind))
                s.mode = (s.depth == '0) ? M_DONE : M_AFTER;
            end
          end
          default: s.err = ERR_UNEXP;
        endcase
      end
    end
  end

  // end-of-text check and clearing
  always_comb begin
    f = s;
    if (f.err == ERR_NONE) begin
      if (f.mode == N_ZERO || f.mode == N_INT || f.mode == N_FRAC || f.mode == N_EXPD)
        f.mode = (f.depth == '0) ? M_DONE : M_AFTER;
      if (f.mode != M_DONE) begin
        if ((f.mode == M_VALUE || f.mode == M_ARR_FIRST) && f.depth > lim)
          f.err = ERR_DEEP;
        else
          f.err = ERR_EARLY;
      end
    end
    res.is_valid = f.err == ERR_NONE;
    res.error_code = f.err;
    nxt = last ? reset_state() : s;
  end

endmodule

// ===== design/json_syntax_validator.sv =====
// top level: byte input register, parser state, result register
//
// json syntax validator
// in: one request per text byte (text_byte, final_byte); out: one request
// carrying is_valid and error_code, given only for the byte flagged final.
// a new byte is taken each cycle unless a final byte waits in the input
// register behind an unread result. the byte is registered at the input
// and checked against the parser state by short logic; for a final byte
// the result is then registered in the output register, and a waiting
// unread result holds the final byte in the input register. throughput is
// one byte per cycle unless a final byte is held back, set by the single
// parser state update. when the receiver stalls, the result register holds;
// bytes keep flowing until a final byte reaches the input register, then
// in.ready falls until the result is taken; nothing is dropped.
// reset (synchronous, rst high) clears the parser, the registers return to
// depth_limit 12 and max_key_bytes 127. after each final byte the parser
// returns to its start state, so texts may follow back to back.
// configuration: cfg_we writes cfg_data into register cfg_index (0 depth_limit,
// 1 max_key_bytes); users must write only while the block is idle (unchecked).
module json_syntax_validator import jsv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  jsv_stream_if.sink           in,
  jsv_stream_if.source         out
);

  logic [3:0] depth_limit;
  logic [7:0] max_key_bytes;
  pstate_t    st;
  pstate_t    st_next;
  result_t    res_next;
  logic       ib_valid;
  logic [7:0] ib_byte;
  logic       ib_last;
  logic       ob_valid;
  result_t    ob_data;
  logic       adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_limit <= 4'd12;
      max_key_bytes <= 8'd127;
    end else if (cfg_we) begin
      if (cfg_index == REG_DEPTH_LIMIT) depth_limit <= cfg_data[3:0];
      else if (cfg_index == REG_MAX_KEY) max_key_bytes <= cfg_data[7:0];
    end
  end

  // the stage advances with a byte in the input register unless a final byte would overwrite a waiting result
  assign adv = ib_valid && !(ib_last && ob_valid && !out.ready);
  assign in.ready = !ib_valid || adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ib_valid <= 1'b0;
    end else if (in.ready) begin
      ib_valid <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in.ready && in.valid) begin
      ib_byte <= in.data.text_byte;
      ib_last <= in.data.final_byte;
    end
  end

  jsv_step u_step (
    .cur           (st),
    .c             (ib_byte),
    .last          (ib_last),
    .depth_limit   (depth_limit),
    .max_key_bytes (max_key_bytes),
    .nxt           (st_next),
    .res           (res_next)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= reset_state();
    end else if (adv) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ob_valid <= 1'b0;
    end else if (adv && ib_last) begin
      ob_valid <= 1'b1;
    end else if (out.ready) begin
      ob_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ib_last) ob_data <= res_next;
  end

  assign out.valid = ob_valid;
  assign out.data = ob_data;

  // a valid result never carries an error code
  assert property (@(posedge clk) disable iff (rst)
    ob_valid |-> (ob_data.is_valid == (ob_data.error_code == ERR_NONE)))
    else $error("result flag disagrees with error code");

  // a stalled result is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    (ob_valid && !out.ready) |=> (ob_valid && $stable(ob_data)))
    else $error("waiting result lost");

  // depth never exceeds the stack
  assert property (@(posedge clk) disable iff (rst)
    st.depth <= (DEPTH_W)'(STACK_DEPTH))
    else $error("nesting depth overflow");

  // parser returns to start after a final byte
  assert property (@(posedge clk) disable iff (rst)
    (adv && ib_last) |=> (st.mode == M_VALUE && st.depth == '0 && st.err == ERR_NONE))
    else $error("parser not cleared after final byte");

endmodule
